>>> hdl/ali_pkg.sv
// Shared types, constants and helper functions for the arc and line interpolator.
package ali_pkg;

  localparam int CW = 34;
  localparam int ZW = 32;

  localparam logic signed [ZW-1:0] PI_Q      = 32'sd843314857;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 32'sd421657428;
  localparam logic signed [ZW-1:0] TWO_PI_Q  = 32'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;
  localparam logic [4:0]           CORDIC_LAST = 5'd27;

  localparam logic [2:0] MODE_FEED   = 3'd0;
  localparam logic [2:0] MODE_RAPID  = 3'd1;
  localparam logic [2:0] MODE_CW     = 3'd2;
  localparam logic [2:0] MODE_CCW    = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;
  localparam logic [2:0] MODE_SETPOS = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEED = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctrl_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0: v = 32'sd210828714;
      5'd1: v = 32'sd124459457;
      5'd2: v = 32'sd65760959;
      5'd3: v = 32'sd33381290;
      5'd4: v = 32'sd16755422;
      5'd5: v = 32'sd8385879;
      5'd6: v = 32'sd4193963;
      5'd7: v = 32'sd2097109;
      5'd8: v = 32'sd1048571;
      5'd9: v = 32'sd524287;
      default: v = 32'sd1 <<< (5'd28 - i);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sd2147483647;
    else if (v < -34'sd2147483647) r = -32'sd2147483647;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -38'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hdl/ali_cordic.sv
// Iterative CORDIC, vectoring or rotation, one micro-rotation per cycle.
module ali_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  ali_pkg::cordic_ctrl_t          ctrl,
  input  logic signed [ali_pkg::CW-1:0]  x0,
  input  logic signed [ali_pkg::CW-1:0]  y0,
  input  logic signed [ali_pkg::ZW-1:0]  z0,
  output logic signed [ali_pkg::CW-1:0]  x,
  output logic signed [ali_pkg::CW-1:0]  y,
  output logic signed [ali_pkg::ZW-1:0]  z,
  output logic                           done
);
  import ali_pkg::*;

  logic                 running;
  logic [4:0]           step;
  logic                 vec;
  logic                 plus;
  logic signed [CW-1:0] xsh, ysh;
  logic signed [ZW-1:0] da;

  always_comb begin
    plus = vec ? (y > 0) : (z < 0);
    xsh  = y >>> step;
    ysh  = x >>> step;
    da   = atan_step(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
      vec     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
        step    <= '0;
        vec     <= ctrl.vec;
      end else if (running) begin
        step <= step + 5'd1;
        if (step == CORDIC_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x <= x0;
      y <= y0;
      z <= z0;
    end else if (running) begin
      if (plus) begin
        x <= x + xsh;
        y <= y - ysh;
        z <= z + da;
      end else begin
        x <= x - xsh;
        y <= y + ysh;
        z <= z - da;
      end
    end
  end

endmodule

>>> hdl/arc_line_interpolator.sv
// Top level: command sequencer, shared multiplier, square root and divider.
//
// Input words arrive on s_axis (mode in tuser), result words leave on m_axis.
// One command is taken at a time; s_axis_tready is high only while idle.
// Stop, set-position, bad-feed and busy answers and linear moves each give
// one word.
// An arc runs: multiplies, normalising, CORDIC atan2, CORDIC sine, then the
// square-root and chord-count steps (skipped when the chord is below the
// tolerance; at most MAX_SEGMENTS chords), two divisions and CORDIC for the
// step angle; then the chords follow one by one, all on the one multiplier
// and one CORDIC unit.
// A result word sits in an output register; while the receiver stalls the
// sequencer holds at the next word and waits.
// Reset (rst, synchronous) zeroes the position, clears the pending stop,
// sets arc_tolerance to 131 and empties the output register.
// cfg_we writes arc_tolerance from cfg_wdata; write only while idle.
module arc_line_interpolator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_0, target_1, target_2, offset_first, offset_second, radius,
  // plane_first, plane_second, helix_axis, feed, zero fill
  input  logic [231:0] s_axis_tdata,
  // mode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_0, pos_1, pos_2, seg_feed
  output logic [127:0] m_axis_tdata,
  // rapid, is_move, status
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import ali_pkg::*;

  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_SEGMENTS);
  localparam logic [NW-1:0] NMIN = NW'(8);
  localparam logic signed [68:0] ROUND = 69'sh2000_0000;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_CMD   = 23'h000002,
    S_PREP  = 23'h000004,
    S_XY    = 23'h000008,
    S_ATAN0 = 23'h000010,
    S_NORM  = 23'h000020,
    S_VEC   = 23'h000040,
    S_ADJ   = 23'h000080,
    S_ARC   = 23'h000100,
    S_SIN   = 23'h000200,
    S_CHORD = 23'h000400,
    S_TOLM  = 23'h000800,
    S_SQ0   = 23'h001000,
    S_SQ    = 23'h002000,
    S_SQD   = 23'h004000,
    S_CNT   = 23'h008000,
    S_DIVA  = 23'h010000,
    S_DIV   = 23'h020000,
    S_ROTW  = 23'h040000,
    S_LOOP  = 23'h080000,
    S_RMUL  = 23'h100000,
    S_EMIT  = 23'h200000,
    S_FINAL = 23'h400000
  } state_t;

  state_t state;

  logic [15:0]        tol;
  logic signed [31:0] cur [3];
  logic               stop;

  logic [2:0]         mode;
  logic signed [31:0] tgt [3];
  logic signed [31:0] off0, off1, feed;
  logic [30:0]        rad;
  logic [1:0]         pf, ps, ph;

  logic signed [32:0] c0, c1;
  logic signed [31:0] rt0, rt1, o0, o1;
  logic               lin_neg;
  logic [31:0]        lin_mag;

  logic [2:0]         ms;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod, acc;

  logic signed [65:0] ysum, xsum;
  logic [64:0]        ux, uy;
  logic signed [31:0] zang, ang;
  logic [34:0]        arc_len;
  logic [30:0]        sval;
  logic [48:0]        sqv, sqres, sqbit;
  logic [35:0]        cacc;
  logic [NW-1:0]      q, n, k;
  logic [31:0]        dvd;
  logic [NW-1:0]      drem;
  logic [4:0]         dcnt;
  logic               dsel;
  logic signed [31:0] th;
  logic [31:0]        ql;
  logic [NW-1:0]      rl;
  logic signed [32:0] sn, cs;
  logic signed [34:0] r0, r1, nr0;
  logic [32:0]        hq;
  logic [NW:0]        hr;

  logic               m_valid;
  logic [31:0]        m_pos [3];
  logic [31:0]        m_feed;
  logic               m_rapid, m_move, m_last;
  logic [1:0]         m_status;

  // CORDIC
  cordic_ctrl_t       cctl;
  logic signed [CW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;
  logic               cdone;

  ali_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cctl),
    .x0   (cx0),
    .y0   (cy0),
    .z0   (cz0),
    .x    (cx),
    .y    (cy),
    .z    (cz),
    .done (cdone)
  );

  // combinational helpers
  logic [1:0]         in_pf, in_ps, in_ph;
  logic signed [32:0] c0_w, c1_w, lin_w;
  logic               slot_free, big;
  logic signed [CW-1:0] xs_n, ys_n, fx, fy;
  logic signed [ZW-1:0] fz, zc, neg_ang, ra, rc, ra_f;
  logic               ra_flip;
  logic [30:0]        aabs;
  logic signed [68:0] rnd_sub, rnd_add;
  logic [48:0]        sq_t;
  logic [NW:0]        rem_s, hr_sum;
  logic               ge;
  logic [NW-1:0]      dnew;
  logic [31:0]        dvd_n;
  logic signed [37:0] pc0, pc1, linq, hel;
  logic signed [37:0] pv [3];

  always_comb begin
    in_pf = (s_axis_tdata[192:191] == 2'd3) ? 2'd2 : s_axis_tdata[192:191];
    in_ps = (s_axis_tdata[194:193] == 2'd3) ? 2'd2 : s_axis_tdata[194:193];
    in_ph = (s_axis_tdata[196:195] == 2'd3) ? 2'd2 : s_axis_tdata[196:195];

    c0_w  = 33'(cur[pf]) + 33'(off0);
    c1_w  = 33'(cur[ps]) + 33'(off1);
    lin_w = 33'(tgt[ph]) - 33'(cur[ph]);

    slot_free = !m_valid || m_axis_tready;
    big = |(ux[64:29] | uy[64:29]);

    xs_n = xsum[65] ? -$signed({5'b0, ux[28:0]}) : $signed({5'b0, ux[28:0]});
    ys_n = ysum[65] ? -$signed({5'b0, uy[28:0]}) : $signed({5'b0, uy[28:0]});
    if (xs_n < 0) begin
      if (ys_n >= 0) begin
        fx = ys_n;  fy = -xs_n; fz = HALF_PI_Q;
      end else begin
        fx = -ys_n; fy = xs_n;  fz = -HALF_PI_Q;
      end
    end else begin
      fx = xs_n; fy = ys_n; fz = '0;
    end

    if (cz > PI_Q) zc = PI_Q;
    else if (cz < -PI_Q) zc = -PI_Q;
    else zc = cz;

    neg_ang = -ang;
    aabs = ang[31] ? neg_ang[30:0] : ang[30:0];

    ra = (state == S_ARC) ? $signed({2'b0, aabs[30:1]}) : th;
    if (ra > PI_Q) rc = PI_Q;
    else if (ra < -PI_Q) rc = -PI_Q;
    else rc = ra;
    ra_flip = 1'b0;
    ra_f = rc;
    if (rc > HALF_PI_Q) begin
      ra_f = PI_Q - rc; ra_flip = 1'b1;
    end else if (rc < -HALF_PI_Q) begin
      ra_f = -PI_Q - rc; ra_flip = 1'b1;
    end

    cctl.vec   = (state == S_NORM);
    cctl.start = (state == S_NORM && !big) || (state == S_ARC) ||
                 (state == S_DIV && dcnt == 5'd31 && dsel);
    cx0 = cctl.vec ? fx : CORDIC_K;
    cy0 = cctl.vec ? fy : '0;
    cz0 = cctl.vec ? fz : ra_f;

    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_XY: begin
        unique case (ms)
          3'd0:    begin mul_a = 36'(rt1); mul_b = 33'(o0); end
          3'd1:    begin mul_a = 36'(rt0); mul_b = 33'(o1); end
          3'd2:    begin mul_a = 36'(rt0); mul_b = 33'(o0); end
          default: begin mul_a = 36'(rt1); mul_b = 33'(o1); end
        endcase
      end
      S_ARC, S_SIN: begin
        mul_a = $signed({5'b0, rad}); mul_b = $signed({2'b0, aabs});
      end
      S_CHORD: begin
        mul_a = $signed({5'b0, rad}); mul_b = $signed({2'b0, sval});
      end
      S_TOLM: begin
        mul_a = $signed({5'b0, rad}); mul_b = $signed({17'b0, tol});
      end
      S_RMUL: begin
        unique case (ms)
          3'd0:    begin mul_a = 36'(r0); mul_b = cs; end
          3'd1:    begin mul_a = 36'(r1); mul_b = sn; end
          3'd2:    begin mul_a = 36'(r0); mul_b = sn; end
          default: begin mul_a = 36'(r1); mul_b = cs; end
        endcase
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase

    rnd_sub = acc - prod + ROUND;
    rnd_add = acc + prod + ROUND;

    sq_t = sqres + sqbit;

    rem_s = {drem, dvd[31]};
    ge    = rem_s >= {1'b0, n};
    dnew  = ge ? NW'(rem_s - {1'b0, n}) : rem_s[NW-1:0];
    dvd_n = {dvd[30:0], ge};

    hr_sum = hr + {1'b0, rl};

    pc0  = 38'(c0) + 38'(r0);
    pc1  = 38'(c1) + 38'(r1);
    linq = lin_neg ? -$signed({6'b0, ql}) : $signed({6'b0, ql});
    hel  = lin_neg ? -$signed({5'b0, hq}) : $signed({5'b0, hq});
    for (int j = 0; j < 3; j++) begin
      pv[j] = 38'(cur[j]);
      if (pf == 2'(j)) pv[j] = pc0;
      if (ps == 2'(j)) pv[j] = pc1;
      if (ph == 2'(j)) begin
        if (ph == pf || ph == ps) pv[j] = pv[j] + linq;
        else pv[j] = 38'(cur[j]) + hel;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) tol <= 16'd131;
    else if (cfg_we) tol <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      stop    <= 1'b0;
      m_valid <= 1'b0;
      for (int j = 0; j < 3; j++) cur[j] <= '0;
    end else begin
      if (m_valid && m_axis_tready) m_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode   <= s_axis_tuser;
            tgt[0] <= s_axis_tdata[31:0];
            tgt[1] <= s_axis_tdata[63:32];
            tgt[2] <= s_axis_tdata[95:64];
            off0   <= s_axis_tdata[127:96];
            off1   <= s_axis_tdata[159:128];
            rad    <= s_axis_tdata[190:160];
            pf     <= in_pf;
            ps     <= in_ps;
            ph     <= in_ph;
            feed   <= s_axis_tdata[228:197];
            state  <= S_CMD;
          end
        end
        S_CMD: begin
          if (slot_free) begin
            m_feed   <= '0;
            m_rapid  <= 1'b0;
            m_move   <= 1'b0;
            m_last   <= 1'b1;
            m_status <= ST_OK;
            for (int j = 0; j < 3; j++) m_pos[j] <= cur[j];
            state    <= S_IDLE;
            if (mode > MODE_CCW) begin
              m_valid <= 1'b1;
              if (mode == MODE_STOP) stop <= 1'b1;
              if (mode == MODE_SETPOS) begin
                for (int j = 0; j < 3; j++) begin
                  cur[j]   <= tgt[j];
                  m_pos[j] <= tgt[j];
                end
              end
            end else if (mode != MODE_RAPID && feed <= 0) begin
              m_valid  <= 1'b1;
              m_status <= ST_FEED;
            end else if (stop) begin
              stop     <= 1'b0;
              m_valid  <= 1'b1;
              m_status <= ST_BUSY;
            end else if (mode == MODE_FEED || mode == MODE_RAPID) begin
              m_valid <= 1'b1;
              m_feed  <= feed;
              m_rapid <= (mode == MODE_RAPID);
              m_move  <= 1'b1;
              for (int j = 0; j < 3; j++) begin
                cur[j]   <= tgt[j];
                m_pos[j] <= tgt[j];
              end
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          c0      <= c0_w;
          c1      <= c1_w;
          rt0     <= clamp_sym(34'(tgt[pf]) - 34'(c0_w));
          rt1     <= clamp_sym(34'(tgt[ps]) - 34'(c1_w));
          o0      <= clamp_sym(34'(off0));
          o1      <= clamp_sym(34'(off1));
          lin_neg <= lin_w[32];
          lin_mag <= lin_w[32] ? 32'(-lin_w) : lin_w[31:0];
          ms      <= '0;
          state   <= S_XY;
        end
        S_XY: begin
          ms <= ms + 3'd1;
          unique case (ms)
            3'd1, 3'd3: acc <= prod;
            3'd2:       ysum <= 66'(acc - prod);
            3'd4: begin
              xsum  <= 66'(acc + prod);
              state <= S_ATAN0;
            end
            default: ;
          endcase
        end
        S_ATAN0: begin
          if (ysum == 0) begin
            zang  <= xsum[65] ? PI_Q : '0;
            state <= S_ADJ;
          end else begin
            ux    <= xsum[65] ? 65'(-xsum) : xsum[64:0];
            uy    <= ysum[65] ? 65'(-ysum) : ysum[64:0];
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (big) begin
            ux <= ux >> 1;
            uy <= uy >> 1;
          end else begin
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (cdone) begin
            zang  <= zc;
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          if (mode == MODE_CW) ang <= (zang >= 0) ? zang - TWO_PI_Q : zang;
          else ang <= (zang <= 0) ? zang + TWO_PI_Q : zang;
          state <= S_ARC;
        end
        S_ARC: state <= S_SIN;
        S_SIN: begin
          if (cdone) begin
            arc_len <= prod[62:28];
            sval    <= cy[CW-1] ? '0 : cy[30:0];
            state   <= S_CHORD;
          end
        end
        S_CHORD: state <= S_TOLM;
        S_TOLM: begin
          if (prod[62:29] < {18'b0, tol}) begin
            n     <= NW'(1);
            state <= S_DIVA;
          end else begin
            state <= S_SQ0;
          end
        end
        S_SQ0: begin
          sqv   <= {prod[47:0], 1'b0};
          sqres <= '0;
          sqbit <= 49'h1_0000_0000_0000;
          state <= S_SQ;
        end
        S_SQ: begin
          if (sqv >= sq_t) begin
            sqv   <= sqv - sq_t;
            sqres <= (sqres >> 1) + sqbit;
          end else begin
            sqres <= sqres >> 1;
          end
          sqbit <= sqbit >> 2;
          if (sqbit[0]) state <= S_SQD;
        end
        S_SQD: begin
          if (sqres == 0) begin
            n     <= NMAX;
            state <= S_DIVA;
          end else begin
            cacc  <= {11'b0, sqres[24:0]};
            q     <= NW'(1);
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (cacc >= {1'b0, arc_len} || q == NMAX) begin
            n     <= (q < NMIN) ? NMIN : q;
            state <= S_DIVA;
          end else begin
            cacc <= cacc + {11'b0, sqres[24:0]};
            q    <= q + NW'(1);
          end
        end
        S_DIVA: begin
          dvd   <= {1'b0, aabs};
          drem  <= '0;
          dcnt  <= '0;
          dsel  <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            if (!dsel) begin
              th   <= ang[31] ? -$signed(dvd_n) : $signed(dvd_n);
              dvd  <= lin_mag;
              drem <= '0;
              dsel <= 1'b1;
            end else begin
              ql    <= dvd_n;
              rl    <= dnew;
              state <= S_ROTW;
            end
          end else begin
            dvd  <= dvd_n;
            drem <= dnew;
          end
        end
        S_ROTW: begin
          if (cdone) begin
            sn    <= cy[32:0];
            cs    <= ra_flip ? 33'(-cx) : cx[32:0];
            r0    <= -35'(o0);
            r1    <= -35'(o1);
            k     <= NW'(1);
            hq    <= {1'b0, ql};
            hr    <= {1'b0, rl};
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          ms    <= '0;
          state <= (k < n) ? S_RMUL : S_FINAL;
        end
        S_RMUL: begin
          ms <= ms + 3'd1;
          unique case (ms)
            3'd1, 3'd3: acc <= prod;
            3'd2:       nr0 <= rnd_sub[64:30];
            3'd4: begin
              r1    <= rnd_add[64:30];
              r0    <= nr0;
              state <= S_EMIT;
            end
            default: ;
          endcase
        end
        S_EMIT: begin
          if (slot_free) begin
            m_valid  <= 1'b1;
            for (int j = 0; j < 3; j++) m_pos[j] <= sat32(pv[j]);
            m_feed   <= feed;
            m_rapid  <= 1'b0;
            m_move   <= 1'b1;
            m_status <= ST_OK;
            m_last   <= 1'b0;
            k        <= k + NW'(1);
            if (hr_sum >= {1'b0, n}) begin
              hr <= hr_sum - {1'b0, n};
              hq <= hq + {1'b0, ql} + 33'd1;
            end else begin
              hr <= hr_sum;
              hq <= hq + {1'b0, ql};
            end
            state <= S_LOOP;
          end
        end
        S_FINAL: begin
          if (slot_free) begin
            m_valid  <= 1'b1;
            for (int j = 0; j < 3; j++) begin
              m_pos[j] <= tgt[j];
              cur[j]   <= tgt[j];
            end
            m_feed   <= feed;
            m_rapid  <= 1'b0;
            m_move   <= 1'b1;
            m_status <= ST_OK;
            m_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_feed, m_pos[2], m_pos[1], m_pos[0]};
  assign m_axis_tuser  = {m_status, m_move, m_rapid};
  assign m_axis_tlast  = m_last;

endmodule
